// ===== hdl/tyu_pkg.sv =====
`default_nettype none
package tyu_pkg;

  localparam int unsigned DefMaxWidth  = 1280;
  localparam int unsigned DefMaxHeight = 1024;
  localparam int unsigned QueueDepth   = 4;

  localparam int unsigned DimW   = 11;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned AddrW  = 21;
  localparam int unsigned PosW   = 12;
  localparam int unsigned PlaneW = 22;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [DimW-1:0] ResetWidth  = 11'd640;
  localparam logic [DimW-1:0] ResetHeight = 11'd480;
  localparam logic [DimW-1:0] TileW       = 11'd16;
  localparam logic [DimW-1:0] TileH       = 11'd8;

  localparam logic [7:0] LumaBytes    = 8'd128;
  localparam logic [7:0] ChromaBStart = 8'd160;
  localparam logic [7:0] BlockLast    = 8'd191;

  localparam logic [CfgIdxW-1:0] CfgFrameWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgFrameHeight = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgSwapChroma  = 2'd2;

  typedef struct packed {
    logic [DimW-1:0] width;
    logic [DimW-1:0] height;
  } dims_t;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             last;
    logic             luma;
    logic             second;
    logic [PosW-1:0]  yrow;
    logic [PosW-1:0]  xoff;
  } item_t;

endpackage
`default_nettype wire

// ===== hdl/tyu_front.sv =====
`default_nettype none
module tyu_front #(
  parameter int unsigned MAX_WIDTH  = tyu_pkg::DefMaxWidth,
  parameter int unsigned MAX_HEIGHT = tyu_pkg::DefMaxHeight
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [tyu_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [tyu_pkg::DimW-1:0]     cfg_data_i,
  input  wire logic                         in_valid_i,
  input  wire logic [tyu_pkg::ByteW-1:0]    in_data_i,
  input  wire logic                         q_ready_i,
  output tyu_pkg::item_t                    q_item_o,
  output tyu_pkg::dims_t                    dims_o
);

  logic [tyu_pkg::DimW-1:0] width_q, height_q;
  logic                     swap_q;
  logic [7:0]               blk_q, blk_d;
  logic [tyu_pkg::DimW-1:0] tx_q, tx_d, ty_q, ty_d;
  logic [tyu_pkg::DimW-1:0] w, h, wm, hm;
  logic [tyu_pkg::PosW-1:0] nx, ny;
  logic                     luma, is_b;
  logic [4:0]               k;
  logic                     accept;

  always_comb begin
    wm = {width_q[tyu_pkg::DimW-1:4], 4'b0};
    hm = {height_q[tyu_pkg::DimW-1:3], 3'b0};
    w  = wm;
    h  = hm;
    if (wm < tyu_pkg::TileW) w = tyu_pkg::TileW;
    if (32'(wm) > MAX_WIDTH) w = tyu_pkg::DimW'(MAX_WIDTH);
    if (hm < tyu_pkg::TileH) h = tyu_pkg::TileH;
    if (32'(hm) > MAX_HEIGHT) h = tyu_pkg::DimW'(MAX_HEIGHT);
  end

  assign dims_o = '{width: w, height: h};
  assign accept = in_valid_i && q_ready_i;

  assign nx   = {1'b0, tx_q} + {1'b0, tyu_pkg::TileW};
  assign ny   = {1'b0, ty_q} + {1'b0, tyu_pkg::TileH};
  assign luma = blk_q < tyu_pkg::LumaBytes;
  assign is_b = blk_q >= tyu_pkg::ChromaBStart;
  assign k    = blk_q[4:0];

  always_comb begin
    q_item_o.data   = in_data_i;
    q_item_o.luma   = luma;
    q_item_o.second = is_b ^ swap_q;
    q_item_o.last   = (blk_q == tyu_pkg::BlockLast) && (nx >= {1'b0, w}) && (ny >= {1'b0, h});
    if (luma) begin
      q_item_o.yrow = {1'b0, ty_q} + tyu_pkg::PosW'(blk_q[5:3]);
      q_item_o.xoff = {1'b0, tx_q} + tyu_pkg::PosW'({blk_q[6], blk_q[2:0]});
    end else begin
      q_item_o.yrow = tyu_pkg::PosW'(ty_q[tyu_pkg::DimW-1:1]) + tyu_pkg::PosW'(k[4:3]);
      q_item_o.xoff = tyu_pkg::PosW'(tx_q[tyu_pkg::DimW-1:1]) + tyu_pkg::PosW'(k[2:0]);
    end
  end

  always_comb begin
    blk_d = blk_q;
    tx_d  = tx_q;
    ty_d  = ty_q;
    if (accept) begin
      if (blk_q >= tyu_pkg::BlockLast) begin
        blk_d = '0;
        if (nx >= {1'b0, w}) begin
          tx_d = '0;
          ty_d = (ny >= {1'b0, h}) ? '0 : ny[tyu_pkg::DimW-1:0];
        end else begin
          tx_d = nx[tyu_pkg::DimW-1:0];
        end
      end else begin
        blk_d = blk_q + 8'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= tyu_pkg::ResetWidth;
      height_q <= tyu_pkg::ResetHeight;
      swap_q   <= 1'b0;
      blk_q    <= '0;
      tx_q     <= '0;
      ty_q     <= '0;
    end else begin
      blk_q <= blk_d;
      tx_q  <= tx_d;
      ty_q  <= ty_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          tyu_pkg::CfgFrameWidth:  width_q  <= cfg_data_i;
          tyu_pkg::CfgFrameHeight: height_q <= cfg_data_i;
          tyu_pkg::CfgSwapChroma:  swap_q   <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/tyu_queue.sv =====
`default_nettype none
module tyu_queue #(
  parameter int unsigned DEPTH = tyu_pkg::QueueDepth
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  input  wire tyu_pkg::item_t in_item_i,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output tyu_pkg::item_t out_item_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  tyu_pkg::item_t     mem_q [DEPTH];
  logic [AW-1:0]      wr_q, rd_q;
  logic [CW-1:0]      cnt_q;
  logic               push, pop;

  assign in_ready_o  = cnt_q != CW'(DEPTH);
  assign out_valid_o = cnt_q != '0;
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_ready_i && out_valid_o;
  assign out_item_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= in_item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
      if (pop)  rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
      if (push && !pop) cnt_q <= cnt_q + CW'(1);
      else if (pop && !push) cnt_q <= cnt_q - CW'(1);
    end
  end

endmodule
`default_nettype wire

// ===== hdl/tyu_back.sv =====
`default_nettype none
module tyu_back (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire tyu_pkg::dims_t            dims_i,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire tyu_pkg::item_t            in_item_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic [tyu_pkg::AddrW-1:0]      out_addr_o,
  output logic [tyu_pkg::ByteW-1:0]      out_data_o,
  output logic                           out_last_o
);

  logic                          v1_q, v2_q;
  logic                          adv1, adv2;
  logic [tyu_pkg::PlaneW-1:0]    plane_q;
  logic [tyu_pkg::DimW-1:0]      mult;
  logic [tyu_pkg::AddrW-1:0]     prod_q;
  tyu_pkg::item_t                s1_q;
  logic [tyu_pkg::AddrW-1:0]     base;
  logic [tyu_pkg::AddrW-1:0]     addr_q;
  logic [tyu_pkg::ByteW-1:0]     data_q;
  logic                          last_q;

  assign adv2       = !v2_q || out_ready_i;
  assign adv1       = !v1_q || adv2;
  assign in_ready_o = adv1;

  assign mult = in_item_i.luma ? dims_i.width : {1'b0, dims_i.width[tyu_pkg::DimW-1:1]};

  always_comb begin
    base = '0;
    if (!s1_q.luma) begin
      base = plane_q[tyu_pkg::AddrW-1:0];
      if (s1_q.second) base = base + tyu_pkg::AddrW'(plane_q >> 2);
    end
  end

  always_ff @(posedge clk_i) begin
    plane_q <= dims_i.width * dims_i.height;
    if (adv1 && in_valid_i) begin
      s1_q   <= in_item_i;
      prod_q <= tyu_pkg::AddrW'(in_item_i.yrow * mult);
    end
    if (adv2 && v1_q) begin
      addr_q <= prod_q + tyu_pkg::AddrW'(s1_q.xoff) + base;
      data_q <= s1_q.data;
      last_q <= s1_q.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= in_valid_i;
      if (adv2) v2_q <= v1_q;
    end
  end

  assign out_valid_o = v2_q;
  assign out_addr_o  = addr_q;
  assign out_data_o  = data_q;
  assign out_last_o  = last_q;

endmodule
`default_nettype wire

// ===== hdl/tiled_yuv_to_planar_i420_scatter.sv =====
// An accepted byte passes through the queue, then the product and address registers of the back end.
// Throughput: one item per cycle while the master side is ready; the tile counters
// step on each accepted byte and the address product runs in its own pipeline stage.
// A 4-entry queue parts the counter front from the address back end.
// Reset: frame 640x480, normal chroma order, counters at the first tile,
// queue and pipeline empty.
`default_nettype none
module tiled_yuv_to_planar_i420_scatter #(
  parameter int unsigned MAX_WIDTH  = tyu_pkg::DefMaxWidth,
  parameter int unsigned MAX_HEIGHT = tyu_pkg::DefMaxHeight
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [tyu_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [tyu_pkg::DimW-1:0]    cfg_data_i,
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire logic [7:0]                  s_axis_tdata,  // [7:0] raw_byte
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  output logic [31:0]                      m_axis_tdata,  // [20:0] dest_address, [28:21] dest_byte
  output logic                             m_axis_tlast   // frame_last
);

  tyu_pkg::item_t                front_item, back_item;
  tyu_pkg::dims_t                dims;
  logic                          q_ready, q_valid, back_ready;
  logic [tyu_pkg::AddrW-1:0]     addr;
  logic [tyu_pkg::ByteW-1:0]     data;

  tyu_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (s_axis_tvalid),
    .in_data_i  (s_axis_tdata),
    .q_ready_i  (q_ready),
    .q_item_o   (front_item),
    .dims_o     (dims)
  );

  tyu_queue #(
    .DEPTH (tyu_pkg::QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (q_ready),
    .in_item_i   (front_item),
    .out_valid_o (q_valid),
    .out_ready_i (back_ready),
    .out_item_o  (back_item)
  );

  tyu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .dims_i      (dims),
    .in_valid_i  (q_valid),
    .in_ready_o  (back_ready),
    .in_item_i   (back_item),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_addr_o  (addr),
    .out_data_o  (data),
    .out_last_o  (m_axis_tlast)
  );

  assign s_axis_tready = q_ready;
  assign m_axis_tdata  = {3'b000, data, addr};

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tyu_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgUnusedIdx = 2'd3;
  localparam int unsigned        ItemTarget   = 1100;
  localparam int unsigned        CycleLimit   = 200000;
  localparam int unsigned        HoldCycles   = 120;

  typedef struct packed {
    logic [AddrW-1:0] addr;
    logic [ByteW-1:0] data;
    logic             last;
  } dest_t;

  class i420_addr_tracker;
    logic [DimW-1:0] width;
    logic [DimW-1:0] height;
    logic            swap;
    int unsigned     offset;
    int unsigned     tile_x;
    int unsigned     tile_y;
    dest_t           pending_dest[$];
    int unsigned     errors;

    function void reset();
      width  = ResetWidth;
      height = ResetHeight;
      swap   = 1'b0;
      offset = 0;
      tile_x = 0;
      tile_y = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [DimW-1:0] val);
      case (idx)
        CfgFrameWidth:  width = val;
        CfgFrameHeight: height = val;
        CfgSwapChroma:  swap = val[0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return pending_dest.size();
    endfunction

    function void note_byte(logic [ByteW-1:0] b);
      int unsigned w, h, plane, addr, k;
      bit          second;
      dest_t       d;
      w = width & ~32'hF;
      if (w < 16) w = 16;
      if (w > DefMaxWidth) w = DefMaxWidth;
      h = height & ~32'h7;
      if (h < 8) h = 8;
      if (h > DefMaxHeight) h = DefMaxHeight;
      plane = w * h;
      if (offset < LumaBytes) begin
        addr = (tile_y + ((offset >> 3) & 7)) * w + tile_x
             + ((offset >> 6) << 3) + (offset & 7);
      end else begin
        k = (offset - LumaBytes) & 31;
        second = (offset >= ChromaBStart) != swap;
        addr = plane + ((tile_y >> 1) + (k >> 3)) * (w >> 1) + (tile_x >> 1) + (k & 7);
        if (second) addr += plane >> 2;
      end
      d.addr = addr[AddrW-1:0];
      d.data = b;
      d.last = (offset == BlockLast) && (tile_x + 16 >= w) && (tile_y + 8 >= h);
      pending_dest.push_back(d);
      if (offset >= BlockLast) begin
        offset = 0;
        tile_x += 16;
        if (tile_x >= w) begin
          tile_x = 0;
          tile_y += 8;
          if (tile_y >= h) tile_y = 0;
        end
        tile_x &= 32'h7FF;
        tile_y &= 32'h7FF;
      end else begin
        offset++;
      end
    endfunction

    task report_mismatch(string msg);
      if (errors < 40) $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_dest(logic [AddrW-1:0] addr, logic [ByteW-1:0] data, logic last);
      dest_t d;
      if (pending_dest.size() == 0) begin
        report_mismatch($sformatf("unexpected item addr=%0d", addr));
      end else begin
        d = pending_dest.pop_front();
        if (addr !== d.addr)
          report_mismatch($sformatf("address %0d, want %0d", addr, d.addr));
        if (data !== d.data)
          report_mismatch($sformatf("byte %02h, want %02h at %0d", data, d.data, d.addr));
        if (last !== d.last)
          report_mismatch($sformatf("frame end %b, want %b at %0d", last, d.last, d.addr));
      end
    endtask
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [DimW-1:0]   cfg_data_i = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [7:0]        s_axis_tdata = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [31:0]       m_axis_tdata;
  logic              m_axis_tlast;

  i420_addr_tracker tracker = new();
  bit               calm = 1'b0;
  bit               hold_req = 1'b0;
  bit               hold_done = 1'b0;
  int unsigned      hold_left = 0;
  int unsigned      cycle_count = 0;
  int unsigned      sent = 0;

  tiled_yuv_to_planar_i420_scatter dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (hold_req && !hold_done) begin
      hold_left = HoldCycles;
      hold_done = 1'b1;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 99) < 38) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      tracker.check_dest(m_axis_tdata[20:0], m_axis_tdata[28:21], m_axis_tlast);
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [DimW-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    tracker.write_reg(idx, val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_byte(input logic [7:0] b);
    @(negedge clk_i);
    while (!calm && $urandom_range(0, 99) < 38) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk_i);
    while (!(s_axis_tvalid && s_axis_tready)) @(posedge clk_i);
    tracker.note_byte(b);
    sent++;
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [DimW-1:0] pick_dim(input int unsigned unit, input int unsigned top);
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 12) return DimW'(unit * $urandom_range(1, 3));
    if (r < 14) return DimW'($urandom_range(0, 4 * unit - 1));
    if (r == 14) return '0;
    if (r == 15) return '1;
    if (r == 16) return DimW'(top);
    if (r == 17) return DimW'(top - 1);
    return DimW'($urandom_range(0, 2047));
  endfunction

  initial begin
    logic [7:0]  corner_bytes[8];
    int unsigned phase;
    int unsigned burst;
    corner_bytes = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h55, 8'hAA, 8'h7F, 8'hFE};
    tracker.reset();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (corner_bytes[i]) send_byte(corner_bytes[i]);
    drain();
    write_reg(CfgFrameWidth, 11'd0);
    write_reg(CfgFrameHeight, 11'h7FF);
    write_reg(CfgSwapChroma, 11'd1);
    write_reg(CfgUnusedIdx, 11'h5A5);
    foreach (corner_bytes[i]) send_byte(~corner_bytes[i]);
    drain();
    write_reg(CfgFrameWidth, 11'h7FF);
    write_reg(CfgFrameHeight, 11'd0);
    write_reg(CfgSwapChroma, 11'h7FE);
    foreach (corner_bytes[i]) send_byte(corner_bytes[i] ^ 8'h3C);
    drain();

    phase = 0;
    while (sent < ItemTarget) begin
      if ($urandom_range(0, 1)) write_reg(CfgFrameWidth, pick_dim(16, DefMaxWidth));
      if ($urandom_range(0, 1)) write_reg(CfgFrameHeight, pick_dim(8, DefMaxHeight));
      if ($urandom_range(0, 1)) write_reg(CfgSwapChroma, DimW'($urandom_range(0, 2047)));
      if ($urandom_range(0, 3) == 0) write_reg(CfgUnusedIdx, DimW'($urandom_range(0, 2047)));
      calm = (phase == 1);
      burst = $urandom_range(1, 350);
      if (phase == 1) burst = 250;
      if (phase == 3) begin
        burst = 300;
        hold_req = 1'b1;
      end
      if (burst > ItemTarget - sent) burst = ItemTarget - sent;
      repeat (burst) send_byte(8'($urandom_range(0, 255)));
      drain();
      calm = 1'b0;
      phase++;
    end

    repeat (8) @(posedge clk_i);
    if (tracker.pending() != 0)
      tracker.report_mismatch($sformatf("%0d items never came", tracker.pending()));
    if (tracker.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
